### rtl/ray_box_slab_intersection_unit_assert.svh
// Assertion macros used by the checker module of the ray/box slab unit.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef RAY_BOX_SLAB_INTERSECTION_UNIT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RBSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbsi assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RBSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbsi assertion failed");

`endif

### rtl/rbsi_pkg.sv
// Package of the ray/box slab intersection unit: default widths and a shared type.
// Depends on nothing.
`default_nettype none
package rbsi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int AXES        = 3;

    // Per-axis flags that travel beside the dividers.
    typedef struct packed {
        logic [AXES-1:0] par;    // direction component is zero
        logic [AXES-1:0] pmiss;  // parallel axis with the origin outside the slab
    } t_axis_flags;

endpackage
`default_nettype wire

### rtl/rbsi_slab_div.sv
// Pipelined restoring divider, one quotient bit per stage, with signed saturation.
// Depends on nothing outside this file.
`default_nettype none
module rbsi_slab_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [COORD_WIDTH-1:0]        i_num,
    input  wire logic [COORD_WIDTH-1:0]        i_den,
    input  wire logic                          i_neg,
    output logic signed [COORD_WIDTH-1:0]      o_quo
);

    localparam int W  = COORD_WIDTH;
    localparam int NS = COORD_WIDTH + FRAC_BITS;

    localparam logic [NS-1:0] LIM_POS = {{(NS-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [NS-1:0] LIM_NEG = {{(NS-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  MAX_CODE = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MIN_CODE = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]  r_rem [NS];
    logic [NS-1:0] r_quo [NS];
    logic [W-1:0]  r_num [NS];
    logic [W-1:0]  r_den [NS];
    logic          r_neg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [W-1:0]  src_rem;
        logic [NS-1:0] src_quo;
        logic [W-1:0]  src_num;
        logic [W-1:0]  src_den;
        logic          src_neg;
        logic          num_bit;
        logic [W:0]    trial;
        logic [W:0]    diff;
        logic          ge;

        if (s == 0) begin : g_first
            assign src_rem = '0;
            assign src_quo = '0;
            assign src_num = i_num;
            assign src_den = i_den;
            assign src_neg = i_neg;
        end else begin : g_next
            assign src_rem = r_rem[s-1];
            assign src_quo = r_quo[s-1];
            assign src_num = r_num[s-1];
            assign src_den = r_den[s-1];
            assign src_neg = r_neg[s-1];
        end

        // Numerator bits come first; the fraction bits shift in as zeros.
        if (s < W) begin : g_bit
            assign num_bit = src_num[W-1-s];
        end else begin : g_zero
            assign num_bit = 1'b0;
        end

        assign trial = {src_rem, num_bit};
        assign diff  = trial - {1'b0, src_den};
        assign ge    = (trial >= {1'b0, src_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? diff[W-1:0] : trial[W-1:0];
                r_quo[s] <= {src_quo[NS-2:0], ge};
                r_num[s] <= src_num;
                r_den[s] <= src_den;
                r_neg[s] <= src_neg;
            end
        end
    end

    logic [NS-1:0] quo_full;
    logic          quo_neg;
    logic          sat;
    logic [W-1:0]  quo_low;

    assign quo_full = r_quo[NS-1];
    assign quo_neg  = r_neg[NS-1];
    assign sat      = quo_full > (quo_neg ? LIM_NEG : LIM_POS);
    assign quo_low  = quo_full[W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (sat) begin
                o_quo <= quo_neg ? MIN_CODE : MAX_CODE;
            end else begin
                o_quo <= quo_neg ? (~quo_low + 1'b1) : quo_low;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/ray_box_slab_intersection_unit.sv
// Top level of the ray/box slab intersection unit: input preparation, six dividers,
// near/far ordering, entry/exit reduction and the output register. Uses rbsi_pkg and
// rbsi_slab_div.
`default_nettype none
// The unit tests one ray against one axis-aligned box per transfer and returns one
// result per test. It takes a new test in every cycle unless the pipeline is halted,
// and it is fully pipelined. Coordinates are Q16.16 by default, and the six slab
// dividers resolve one quotient bit per stage, each stage a register of its own. The
// whole pipeline advances together; it halts only when the output register and the
// skid register behind it are both full, and o_s_tready is then low. Each slab
// distance is ((plane - origin) << FRAC_BITS) / dir truncated toward zero and
// saturated to the coordinate range. An axis with a zero direction component sets no
// limit when the origin lies between its planes and forces a miss otherwise. A miss
// returns hit = 0 with the most positive code as distance; a hit returns the entry
// distance, which is negative when the origin lies inside the box.
module ray_box_slab_intersection_unit #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // From bit 0 up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad.
    input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // From bit 0 up: hit, distance, zero pad.
    output logic [((COORD_WIDTH+1+7)/8)*8-1:0]          o_m_tdata
);

    localparam int W      = COORD_WIDTH;
    localparam int AXES   = rbsi_pkg::AXES;
    localparam int LANES  = 2 * AXES;
    localparam int DLAT   = COORD_WIDTH + FRAC_BITS + 1;
    localparam int OUT_TW = ((COORD_WIDTH+1+7)/8)*8;

    localparam logic signed [W-1:0] MAX_CODE = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_CODE = {1'b1, {(W-1){1'b0}}};

    // The pipeline moves as one; only a full skid register holds it.
    logic en;
    logic r_sk_valid;
    assign en         = !r_sk_valid;
    assign o_s_tready = en;

    // Preparation stage: slab numerator magnitudes, divisor magnitude and quotient sign.
    logic [W-1:0]          r_p_num [LANES];
    logic [W-1:0]          r_p_den [LANES];
    logic                  r_p_neg [LANES];
    rbsi_pkg::t_axis_flags r_p_flags;
    logic                  r_p_valid;

    rbsi_pkg::t_axis_flags n_p_flags;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic signed [W-1:0] org;
        logic signed [W-1:0] dir;
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        logic signed [W-1:0] p0;
        logic signed [W-1:0] p1;
        logic [W-1:0]        dmag;

        assign org = i_s_tdata[a*W +: W];
        assign dir = i_s_tdata[(3+a)*W +: W];
        assign lo  = i_s_tdata[(6+a)*W +: W];
        assign hi  = i_s_tdata[(9+a)*W +: W];

        assign p0   = (lo < hi) ? lo : hi;
        assign p1   = (lo < hi) ? hi : lo;
        assign dmag = dir[W-1] ? (~dir + 1'b1) : dir;

        assign n_p_flags.par[a]   = (dir == '0);
        assign n_p_flags.pmiss[a] = (dir == '0) && ((org < p0) || (org > p1));

        for (genvar p = 0; p < 2; p++) begin : g_plane
            logic signed [W:0] diff;
            logic [W:0]        mag;

            // The difference is one bit wider so that it never wraps.
            assign diff = (p == 0) ? ({lo[W-1], lo} - {org[W-1], org})
                                   : ({hi[W-1], hi} - {org[W-1], org});
            assign mag  = diff[W] ? (~diff + 1'b1) : diff;

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_p_num[2*a+p] <= mag[W-1:0];
                    r_p_den[2*a+p] <= dmag;
                    r_p_neg[2*a+p] <= diff[W] ^ dir[W-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_flags <= n_p_flags;
        end
    end

    // Six slab dividers, lane 2a for the minimum plane and 2a+1 for the maximum plane.
    logic signed [W-1:0] quo [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_div
        rbsi_slab_div #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_p_num[l]),
            .i_den (r_p_den[l]),
            .i_neg (r_p_neg[l]),
            .o_quo (quo[l])
        );
    end

    // Valid bits and axis flags ride alongside the divider stages.
    logic                  r_dv    [DLAT];
    rbsi_pkg::t_axis_flags r_dflag [DLAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLAT; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r_p_valid;
            for (int i = 1; i < DLAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dflag[0] <= r_p_flags;
            for (int i = 1; i < DLAT; i++) begin
                r_dflag[i] <= r_dflag[i-1];
            end
        end
    end

    // Ordering stage: near and far distance per axis. A parallel axis sets no limit.
    logic signed [W-1:0] r_a_near [AXES];
    logic signed [W-1:0] r_a_far  [AXES];
    logic                r_a_miss;
    logic                r_a_valid;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                if (r_dflag[DLAT-1].par[a]) begin
                    r_a_near[a] <= MIN_CODE;
                    r_a_far[a]  <= MAX_CODE;
                end else if (quo[2*a] < quo[2*a+1]) begin
                    r_a_near[a] <= quo[2*a];
                    r_a_far[a]  <= quo[2*a+1];
                end else begin
                    r_a_near[a] <= quo[2*a+1];
                    r_a_far[a]  <= quo[2*a];
                end
            end
            r_a_miss <= |r_dflag[DLAT-1].pmiss;
        end
    end

    // Reduction stage: the entry is the largest near value, the exit the smallest far.
    logic signed [W-1:0] r_b_entry;
    logic signed [W-1:0] r_b_exit;
    logic                r_b_miss;
    logic                r_b_valid;
    logic signed [W-1:0] n_b_entry;
    logic signed [W-1:0] n_b_exit;
    logic signed [W-1:0] ent01;
    logic signed [W-1:0] ext01;

    assign ent01     = (r_a_near[0] > r_a_near[1]) ? r_a_near[0] : r_a_near[1];
    assign n_b_entry = (ent01 > r_a_near[2]) ? ent01 : r_a_near[2];
    assign ext01     = (r_a_far[0] < r_a_far[1]) ? r_a_far[0] : r_a_far[1];
    assign n_b_exit  = (ext01 < r_a_far[2]) ? ext01 : r_a_far[2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_entry <= n_b_entry;
            r_b_exit  <= n_b_exit;
            r_b_miss  <= r_a_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= r_dv[DLAT-1];
            r_b_valid <= r_a_valid;
        end
    end

    // Decision: a hit needs a non-negative exit that is not before the entry.
    logic              f_hit;
    logic [W-1:0]      f_dist;
    logic [OUT_TW-1:0] f_data;

    assign f_hit  = !r_b_miss && !r_b_exit[W-1] && !(r_b_entry > r_b_exit);
    assign f_dist = f_hit ? r_b_entry : MAX_CODE;
    assign f_data = OUT_TW'({f_dist, f_hit});

    // Output register with a skid register behind it, so a stalled result does not
    // block the transfer that is already on its way.
    logic [OUT_TW-1:0] r_out_data;
    logic [OUT_TW-1:0] r_sk_data;
    logic              r_out_valid;
    logic              take;

    assign take = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (take) begin
                r_out_data <= r_sk_data;
                r_sk_valid <= 1'b0;
            end
        end else if (!r_out_valid || take) begin
            r_out_valid <= r_b_valid;
            r_out_data  <= f_data;
        end else if (r_b_valid) begin
            r_sk_valid <= 1'b1;
            r_sk_data  <= f_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
`default_nettype wire

### rtl/rbsi_checker.sv
// Port-level checker for the ray/box slab intersection unit and its bind statement.
// Depends on ray_box_slab_intersection_unit_assert.svh.
`default_nettype none
`include "ray_box_slab_intersection_unit_assert.svh"
module rbsi_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int OUT_TW      = 40
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_s_tready,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [OUT_TW-1:0] o_m_tdata
);

    localparam logic [COORD_WIDTH-1:0] MAX_CODE = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    // A stalled result holds its value.
    `RBSI_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    // A miss always carries the most positive distance.
    `RBSI_ASSERT_IMP(a_miss_code, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[0], o_m_tdata[COORD_WIDTH:1] == MAX_CODE)
    // Once a result is taken the skid register is empty and input is accepted again.
    `RBSI_ASSERT_NXT(a_drain, i_clk, i_rst_n, o_m_tvalid && i_m_tready, o_s_tready)
    // The input only stalls while a result is waiting.
    `RBSI_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_s_tready, o_m_tvalid)

endmodule

bind ray_box_slab_intersection_unit rbsi_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .OUT_TW      (OUT_TW)
) u_rbsi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

### dv/tb.sv
// Testbench of the ray/box slab intersection unit: directed and random ray/box tests
// checked against a fixed-point slab predictor. Depends on rbsi_pkg and the unit's RTL.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = rbsi_pkg::COORD_WIDTH;
    localparam int FB = rbsi_pkg::FRAC_BITS;
    localparam int IN_W = ((12*W+7)/8)*8;
    localparam int OUT_W = ((W+1+7)/8)*8;
    localparam int LATENCY = W + FB + 5;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic hit;
        logic signed [W-1:0] distance;
    } t_hit_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    ray_box_slab_intersection_unit uut (.*);

    always #5 i_clk = ~i_clk;

    t_hit_result pending_hits[$];
    int error_count = 0;
    int sink_idle_pct = 35;
    int sender_idle_pct = 35;
    bit sink_hold = 1'b0;
    int idle_cycles = 0;

    localparam logic signed [W-1:0] MAXC = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINC = {1'b1, {(W-1){1'b0}}};

    // Truncating quotient of (plane - org) << FB by dir, saturated to W bits.
    function automatic logic signed [W-1:0] slab_dist(logic signed [W-1:0] plane,
                                                      logic signed [W-1:0] org,
                                                      logic signed [W-1:0] dir);
        logic signed [W+1:0] diff;
        logic [W+FB+1:0] num;
        logic [W+FB+1:0] den;
        logic [W+FB+1:0] q;
        bit neg;
        diff = $signed({plane[W-1], plane}) - $signed({org[W-1], org});
        neg = (diff < 0) != (dir < 0);
        num = (diff < 0) ? (W+FB+2)'(-diff) : (W+FB+2)'(diff);
        num = num << FB;
        den = (dir < 0) ? (W+FB+2)'(-$signed({dir[W-1], dir})) : (W+FB+2)'(dir);
        if (num == 0) return '0;
        q = num / den;
        if (neg) begin
            // A magnitude of 2^(W-1) or more lands on the most negative code.
            if (q > {1'b0, MAXC}) return MINC;
            return -$signed(q[W-1:0]);
        end
        if (q > {1'b0, MAXC}) return MAXC;
        return q[W-1:0];
    endfunction

    function automatic t_hit_result predict_hit(logic [IN_W-1:0] item);
        logic signed [W-1:0] o, d, lo, hi, t1, t2, nv, fv, p0, p1;
        logic signed [W-1:0] entry_d, exit_d;
        bit miss;
        t_hit_result res;
        entry_d = MINC;
        exit_d = MAXC;
        miss = 0;
        for (int a = 0; a < 3; a++) begin
            o = item[a*W +: W];
            d = item[(3+a)*W +: W];
            lo = item[(6+a)*W +: W];
            hi = item[(9+a)*W +: W];
            if (d == 0) begin
                p0 = (lo < hi) ? lo : hi;
                p1 = (lo < hi) ? hi : lo;
                if (o < p0 || o > p1) miss = 1;
            end else begin
                t1 = slab_dist(lo, o, d);
                t2 = slab_dist(hi, o, d);
                nv = (t1 < t2) ? t1 : t2;
                fv = (t1 < t2) ? t2 : t1;
                if (nv > entry_d) entry_d = nv;
                if (fv < exit_d) exit_d = fv;
            end
        end
        if (exit_d < 0 || entry_d > exit_d) miss = 1;
        res.hit = !miss;
        res.distance = miss ? MAXC : entry_d;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [W:0] got, logic [W:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Offers one test and waits until its transfer completes. The valid line is
    // only dropped when the sender idles, so back-to-back tests keep it high.
    task automatic send_ray(logic [IN_W-1:0] item);
        while (($urandom_range(99) < sender_idle_pct)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tdata <= item;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_hits.push_back(predict_hit(item));
    endtask

    // Result checker: compares every output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_hit_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[W:0], '0);
            end else begin
                want = pending_hits.pop_front();
                if (o_m_tdata[0] !== want.hit)
                    report_mismatch("hit", o_m_tdata[0], want.hit);
                if (o_m_tdata[W:1] !== want.distance)
                    report_mismatch("distance", o_m_tdata[W:1], want.distance);
            end
        end
    end

    // Receiver readiness, random unless held off.
    always @(posedge i_clk) begin
        i_m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [W-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return W'($signed($urandom_range(40 << FB)) - (20 << FB));
            2: return W'($signed($urandom_range(511)) - 256);
            default: return '0;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] pack_ray(logic [W-1:0] f[12]);
        logic [IN_W-1:0] item;
        item = '0;
        for (int k = 0; k < 12; k++) item[k*W +: W] = f[k];
        return item;
    endfunction

    task automatic test_directed();
        logic [W-1:0] f[12];
        logic [W-1:0] ext[4];
        ext = '{MAXC, MINC, '0, '1};
        // Simple hit from outside, along x.
        f = '{W'(-5 << FB), 0, 0, W'(1 << FB), 0, 0,
              W'(-1 << FB), W'(-1 << FB), W'(-1 << FB), W'(1 << FB), W'(1 << FB), W'(1 << FB)};
        send_ray(pack_ray(f));
        // Origin inside the box: negative entry distance.
        f[0] = 0;
        send_ray(pack_ray(f));
        // Box behind the ray.
        f[0] = W'(5 << FB);
        send_ray(pack_ray(f));
        // Parallel on all axes with the origin inside.
        f[0] = 0; f[3] = 0;
        send_ray(pack_ray(f));
        // Parallel axis with the origin outside.
        f[1] = W'(3 << FB);
        send_ray(pack_ray(f));
        // Inverted box on one axis.
        f[1] = 0; f[3] = W'(1 << FB); f[6] = W'(1 << FB); f[9] = W'(-1 << FB);
        send_ray(pack_ray(f));
        // Tiny direction forces quotient saturation.
        f[0] = W'(-5 << FB); f[3] = 1;
        send_ray(pack_ray(f));
        // Field extremes.
        for (int e = 0; e < 4; e++) begin
            for (int k = 0; k < 12; k++) f[k] = ext[(e + k) % 4];
            send_ray(pack_ray(f));
            for (int k = 0; k < 12; k++) f[k] = ext[e];
            send_ray(pack_ray(f));
        end
        for (int k = 0; k < 12; k++) f[k] = (k % 2) ? MINC : MAXC;
        send_ray(pack_ray(f));
        for (int k = 0; k < 12; k++) f[k] = (k % 2) ? MAXC : MINC;
        send_ray(pack_ray(f));
    endtask

    task automatic test_random(int count);
        logic [W-1:0] f[12];
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(3);
            for (int k = 0; k < 12; k++) begin
                f[k] = rand_coord(mode == 3 ? $urandom_range(3) : mode);
            end
            // Occasionally zero a direction component to exercise parallel axes.
            if ($urandom_range(7) == 0) f[3 + $urandom_range(2)] = '0;
            send_ray(pack_ray(f));
        end
    endtask

    task automatic test_no_idle();
        sender_idle_pct = 0;
        sink_idle_pct = 0;
        test_random(300);
        sender_idle_pct = 35;
        sink_idle_pct = 35;
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering tests.
    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                for (int c = 0; c < 3 * LATENCY; c++) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            test_random(200);
        join
    endtask

    initial begin
        int wait_cycles;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(600);
        test_no_idle();
        test_backpressure();
        test_random(630);
        i_s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_hits.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY) @(posedge i_clk);
        if (error_count == 0 && pending_hits.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
